### rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine: request
// kinds, screen command codes, character codes and the result item layout.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // Field widths of the request and result items
   localparam int unsigned REQ_TYPE_W    = 1;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned CMD_W         = 2;
   localparam int unsigned CELL_COL_W    = 7;
   localparam int unsigned CELL_ROW_W    = 5;
   localparam int unsigned CURSOR_CELL_W = 11;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT       = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_BACKSPACE = 1'b1;

   // Screen commands
   localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_QUERY    = 8'h3F;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

   // One screen command item
   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [CHAR_W-1:0]        cell_char;
      logic [CELL_COL_W-1:0]    cell_col;
      logic [CELL_ROW_W-1:0]    cell_row;
      logic [CURSOR_CELL_W-1:0] cursor_cell;
      logic                     last;
   } rsp_item_type;

endpackage : tcce_pkg
`default_nettype wire

### rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Keeps a text-screen cursor and turns put-character and backspace items into
// draw, scroll and clear-row screen commands.
//
//  channel | dir | tdata                          | tuser        | tlast
//  req_    | in  | char_code                      | req_type     | -
//  rsp_    | out | cell_char, cell_col, cell_row, | cmd          | last
//          |     | cursor_cell                    |              |
//
// An item causing one command lets a new item in as its result is taken;
// newline on the last row and a character at the bottom-right cell cause two,
// and no new item is taken while the second command waits behind the first.
// The cursor is updated in the cycle an item is accepted; results wait in a
// result register plus one second-command register.
// Reset (synchronous) puts the cursor at (0,0) and empties both registers.
// req_tready drops while a second command is pending or a result is stalled.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int unsigned SCREEN_COLS = 80,
   parameter int unsigned SCREEN_ROWS = 25
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic [0:0]  req_tuser,   // [0] req_type
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] cell_char, [14:8] cell_col,
                                         // [19:15] cell_row, [30:20] cursor_cell,
                                         // [31] zero
   output logic [1:0]       rsp_tuser,   // [1:0] cmd
   output logic             rsp_tlast
);

   localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
   localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
   localparam int unsigned PROD_W = COL_W + ROW_W;

   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [PROD_W-1:0] COLS_CONST = PROD_W'(SCREEN_COLS);

   // cursor state
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;

   // result register and second-command register
   logic         rsp_valid_ff,  rsp_valid_in;
   rsp_item_type rsp_item_ff,   rsp_item_in;
   logic         pend_valid_ff, pend_valid_in;
   rsp_item_type pend_item_ff,  pend_item_in;

   logic         take;
   logic         pop;
   logic [CHAR_W-1:0] mapped_char;
   logic [PROD_W-1:0] cell_lin;
   logic         two_cmds;
   rsp_item_type first_item;
   rsp_item_type second_item;

   // handshake
   assign req_tready = !pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;

   // printable mapping: NUL and 32..127 pass, the rest shows as '?'
   always_comb begin
      if (req_tdata != CHAR_NUL &&
          (req_tdata < CHAR_PRINT_LO || req_tdata > CHAR_PRINT_HI)) begin
         mapped_char = CHAR_QUERY;
      end else begin
         mapped_char = req_tdata;
      end
   end

   // next cursor and the commands of this item
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      two_cmds    = 1'b0;
      first_item  = '0;
      second_item = '0;

      priority if (req_tuser[0] == REQ_BACKSPACE) begin
         // step back, wrap to previous row end, saturate at top-left
         if (cur_col_ff == '0) begin
            if (cur_row_ff != '0) begin
               cur_row_in = cur_row_ff - 1'b1;
               cur_col_in = LAST_COL;
            end
         end else begin
            cur_col_in = cur_col_ff - 1'b1;
         end
         first_item.cmd       = CMD_DRAW;
         first_item.cell_char = CHAR_SPACE;
         first_item.cell_col  = CELL_COL_W'(cur_col_in);
         first_item.cell_row  = CELL_ROW_W'(cur_row_in);
      end else if (req_tdata == CHAR_NEWLINE) begin
         // newline: scroll on last row, then clear the new row
         cur_col_in = '0;
         if (cur_row_ff >= LAST_ROW) begin
            cur_row_in          = LAST_ROW;
            two_cmds            = 1'b1;
            first_item.cmd      = CMD_SCROLL;
            second_item.cmd     = CMD_CLEAR;
            second_item.cell_row = CELL_ROW_W'(LAST_ROW);
         end else begin
            cur_row_in          = cur_row_ff + 1'b1;
            first_item.cmd      = CMD_CLEAR;
            first_item.cell_row = CELL_ROW_W'(cur_row_in);
         end
      end else begin
         // draw at cursor, then advance with wrap and scroll
         first_item.cmd       = CMD_DRAW;
         first_item.cell_char = mapped_char;
         first_item.cell_col  = CELL_COL_W'(cur_col_ff);
         first_item.cell_row  = CELL_ROW_W'(cur_row_ff);
         if (cur_col_ff >= LAST_COL) begin
            cur_col_in = '0;
            if (cur_row_ff >= LAST_ROW) begin
               cur_row_in      = LAST_ROW;
               two_cmds        = 1'b1;
               second_item.cmd = CMD_SCROLL;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end else begin
            cur_col_in = cur_col_ff + 1'b1;
         end
      end

      // linear cursor cell after the step, on every command
      cell_lin = PROD_W'(cur_row_in) * COLS_CONST + PROD_W'(cur_col_in);
      first_item.cursor_cell  = CURSOR_CELL_W'(cell_lin);
      second_item.cursor_cell = CURSOR_CELL_W'(cell_lin);
      first_item.last         = !two_cmds;
      second_item.last        = 1'b1;
   end

   // result register steering
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      pend_valid_in = pend_valid_ff;
      pend_item_in  = pend_item_ff;
      priority if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_item_in   = first_item;
         pend_valid_in = two_cmds;
         pend_item_in  = second_item;
      end else if (pop) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_item_in   = pend_item_ff;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      pend_item_ff <= pend_item_in;
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.cmd;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = {1'b0, rsp_item_ff.cursor_cell, rsp_item_ff.cell_row,
                        rsp_item_ff.cell_col, rsp_item_ff.cell_char};

`ifndef ASSERT_OFF
   // a pending second command always sits behind a shown first one
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("second command pending with empty result register");

   // a non-final command always has its successor waiting
   a_not_last_has_pend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.last) |-> pend_valid_ff)
      else $error("non-final command without a following one");

   // cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= LAST_COL) && (cur_row_ff <= LAST_ROW))
      else $error("cursor outside screen");

   // a backspace shows a single space draw next
   a_backspace_draw: assert property (@(posedge clock) disable iff (reset)
      (take && req_tuser[0] == REQ_BACKSPACE) |=>
         (rsp_valid_ff && rsp_item_ff.cmd == CMD_DRAW &&
          rsp_item_ff.cell_char == CHAR_SPACE && rsp_item_ff.last && !pend_valid_ff))
      else $error("backspace did not produce a single space draw");
`endif

endmodule : text_console_cursor_engine
`default_nettype wire
